// File: rtl/core/mhq_pkg.sv
// mhq_pkg: shared types and constants of the multilevel hysteresis quantizer
// used by mhq_cell and multilevel_hysteresis_quantizer_core, no dependencies
package mhq_pkg;

    localparam int DATA_W     = 16;
    localparam int HYST_W     = 12;
    localparam int HALF_W     = HYST_W - 1;
    localparam int LVL_W      = 5;
    localparam int MAX_LEVELS = (1 << LVL_W) - 1;
    localparam int ENTRY_W    = 4;
    localparam int OUT_IDX_W  = 4;
    localparam int CMP_W      = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_HYST   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 1'b1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    // walk state handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic                     climb;
        logic [LVL_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
    } mhq_carry_t;

    // per-request values seen by every cell
    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic [HALF_W-1:0]        half;
        logic [LVL_W-1:0]         used;
        logic [LVL_W-1:0]         start;
    } mhq_job_t;

    // table write broadcast
    typedef struct packed {
        logic                     en;
        logic [ENTRY_W-1:0]       index;
        logic signed [DATA_W-1:0] threshold;
        logic signed [DATA_W-1:0] value;
    } mhq_wr_t;

endpackage

// File: rtl/core/multilevel_hysteresis_quantizer_core.sv
// multilevel_hysteresis_quantizer_core: top level, a chain of mhq_cell stages
// depends on mhq_pkg and mhq_cell
//
// A sample request passes once along a row of min(ENTRIES, 31) cells, one cell
// per clock, each cell holding one table level and applying one step of the
// hysteresis walk. The walk result is caught in a done register and moves to
// the output register once that register is free of a stalled result; in_stall
// drops with that move, so the result waits in the output register while the
// next request is taken. A table write request gives no result. in_stall is
// high while a sample is walking the chain. Configuration writes take effect
// on the next request.
module multilevel_hysteresis_quantizer_core #(
    parameter int ENTRIES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mhq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mhq_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  mode,
    input  logic signed [mhq_pkg::DATA_W-1:0]     sample,
    input  logic [mhq_pkg::ENTRY_W-1:0]           entry_index,
    input  logic signed [mhq_pkg::DATA_W-1:0]     entry_threshold,
    input  logic signed [mhq_pkg::DATA_W-1:0]     entry_output,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mhq_pkg::DATA_W-1:0]     level_value,
    output logic [mhq_pkg::OUT_IDX_W-1:0]         level_index
);
    import mhq_pkg::*;

    localparam int CELLS = (ENTRIES < MAX_LEVELS) ? ENTRIES : MAX_LEVELS;

    logic [HYST_W-1:0]        hyst_reg;
    logic [LVL_W-1:0]         count_reg;
    logic [LVL_W-1:0]         level_reg;
    logic                     busy_reg;
    logic                     head_valid_reg;
    mhq_job_t                 job_reg;
    logic                     done_valid_reg;
    mhq_carry_t               done_reg;
    logic                     out_valid_reg;
    logic [LVL_W-1:0]         out_idx_reg;
    logic signed [DATA_W-1:0] out_value_reg;

    logic             accept;
    logic             sample_acc;
    logic             transfer;
    logic [LVL_W-1:0] used_lvl;
    logic [LVL_W-1:0] start_lvl;
    mhq_wr_t          wr;
    mhq_carry_t       chain [CELLS+1];
    logic [CELLS:0]   chain_valid;

    assign in_stall   = busy_reg;
    assign accept     = in_valid && !busy_reg;
    assign sample_acc = accept && (mode == MODE_SAMPLE);
    assign transfer   = done_valid_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (count_reg == '0)
        begin
            used_lvl = LVL_W'(1);
        end
        else if (count_reg > LVL_W'(CELLS))
        begin
            used_lvl = LVL_W'(CELLS);
        end
        else
        begin
            used_lvl = count_reg;
        end
        // a level left above the count saturates to the top level in use
        start_lvl = (level_reg >= used_lvl) ? (used_lvl - LVL_W'(1)) : level_reg;
    end

    always_comb
    begin
        wr.en        = accept && (mode == MODE_WRITE);
        wr.index     = entry_index;
        wr.threshold = entry_threshold;
        wr.value     = entry_output;
    end

    always_comb
    begin
        chain[0].valid = head_valid_reg;
        chain[0].climb = 1'b0;
        chain[0].idx   = '0;
        chain[0].value = '0;
    end

    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            mhq_cell #(
                .CELL_IDX(g)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .wr    (wr),
                .job   (job_reg),
                .c_in  (chain[g]),
                .c_out (chain[g+1])
            );
        end
        for (g = 0; g <= CELLS; g++)
        begin : g_valid
            assign chain_valid[g] = chain[g].valid;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg       <= HYST_W'(2);
            count_reg      <= LVL_W'(1);
            level_reg      <= '0;
            busy_reg       <= 1'b0;
            head_valid_reg <= 1'b0;
            done_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HYST:   hyst_reg  <= cfg_data;
                    CFG_LEVELS: count_reg <= cfg_data[LVL_W-1:0];
                    default:    ;
                endcase
            end

            head_valid_reg <= sample_acc;
            if (sample_acc)
            begin
                busy_reg <= 1'b1;
            end

            if (chain[CELLS].valid)
            begin
                done_valid_reg <= 1'b1;
            end

            if (transfer)
            begin
                done_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
                level_reg      <= done_reg.idx;
                busy_reg       <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            job_reg.sample <= sample;
            job_reg.half   <= hyst_reg[HYST_W-1:1];
            job_reg.used   <= used_lvl;
            job_reg.start  <= start_lvl;
        end
        if (chain[CELLS].valid)
        begin
            done_reg <= chain[CELLS];
        end
        if (transfer)
        begin
            out_idx_reg   <= done_reg.idx;
            out_value_reg <= done_reg.value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign level_value = out_value_reg;
    assign level_index = out_idx_reg[OUT_IDX_W-1:0];

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> busy_reg)
        else $error("sample request accepted without entering the walk");

    a_chain_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (($countones(chain_valid) == 0) && !done_valid_reg))
        else $error("walk in flight while the block reports idle");

    a_single_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({chain_valid, done_valid_reg}) <= 1)
        else $error("more than one walk in flight");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_idx_reg < LVL_W'(CELLS)))
        else $error("result level beyond the table");

endmodule

// File: rtl/core/mhq_cell.sv
// mhq_cell: one level of the quantizer table plus one step of the level walk
// depends on mhq_pkg
module mhq_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mhq_pkg::mhq_wr_t    wr,
    input  mhq_pkg::mhq_job_t   job,
    input  mhq_pkg::mhq_carry_t c_in,
    output mhq_pkg::mhq_carry_t c_out
);
    import mhq_pkg::*;

    localparam logic [LVL_W-1:0] K = LVL_W'(CELL_IDX);

    logic signed [DATA_W-1:0] bp_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic                     valid_reg;
    mhq_carry_t               data_reg;
    mhq_carry_t               data_next;

    logic signed [CMP_W-1:0] s_x;
    logic signed [CMP_W-1:0] bp_x;
    logic signed [CMP_W-1:0] half_x;
    logic signed [CMP_W-1:0] hi_x;
    logic signed [CMP_W-1:0] lo_x;
    logic                    ge_bp;
    logic                    down_ok;
    logic                    up_ok;

    always_comb
    begin
        s_x     = {{(CMP_W-DATA_W){job.sample[DATA_W-1]}}, job.sample};
        bp_x    = {{(CMP_W-DATA_W){bp_reg[DATA_W-1]}}, bp_reg};
        half_x  = {{(CMP_W-HALF_W){1'b0}}, job.half};
        hi_x    = bp_x + half_x;
        lo_x    = bp_x - half_x;
        ge_bp   = (s_x >= bp_x);
        // level 0 is the floor of a downward walk
        down_ok = (K == '0) || (s_x >= lo_x);
        up_ok   = (K < job.used) && (s_x >= hi_x);

        data_next = c_in;
        if (K < job.start)
        begin
            // candidate for a downward walk, the highest passing level wins
            if (down_ok)
            begin
                data_next.idx   = K;
                data_next.value = val_reg;
            end
        end
        else if (K == job.start)
        begin
            if (ge_bp)
            begin
                data_next.idx   = K;
                data_next.value = val_reg;
                data_next.climb = 1'b1;
            end
            else
            begin
                data_next.climb = 1'b0;
                if (down_ok)
                begin
                    data_next.idx   = K;
                    data_next.value = val_reg;
                end
            end
        end
        else
        begin
            if (c_in.climb && up_ok)
            begin
                data_next.idx   = K;
                data_next.value = val_reg;
            end
            else
            begin
                data_next.climb = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= c_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (wr.en && (LVL_W'(wr.index) == K))
        begin
            bp_reg  <= wr.threshold;
            val_reg <= wr.value;
        end
    end

    always_comb
    begin
        c_out       = data_reg;
        c_out.valid = valid_reg;
    end

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for multilevel_hysteresis_quantizer_core
// depends on mhq_pkg and the core; directed table first, then random phases
`timescale 1ns / 100ps

module tb_top;
    import mhq_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int ITEMS_TOTAL  = 1400;
    localparam int QUIET_ITEMS  = 150;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 24;
    localparam int DIR_ROWS     = 24;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [OUT_IDX_W-1:0]     index;
    } level_result_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e                kind;
        logic signed [DATA_W-1:0] smp;
        logic [ENTRY_W-1:0]       idx;
        logic signed [DATA_W-1:0] thr;
        logic signed [DATA_W-1:0] outv;
        logic [CFG_IDX_W-1:0]     reg_sel;
        logic [CFG_DATA_W-1:0]    reg_val;
        logic                     fixed;
        level_result_t            res;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     mode;
    logic signed [DATA_W-1:0] sample;
    logic [ENTRY_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] entry_threshold;
    logic signed [DATA_W-1:0] entry_output;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] level_value;
    logic [OUT_IDX_W-1:0]     level_index;

    // shadow state of the quantizer
    logic [HYST_W-1:0] band_width;
    logic [LVL_W-1:0]  levels_set;
    int                cur_level;
    int                rise_point [ENTRIES];
    int                level_out [ENTRIES];

    level_result_t expected_levels [$];
    dir_row_t      dir_rows [DIR_ROWS];
    int            error_count;
    int            item_count;
    bit            idle_on;
    bit            quiet;
    int            stall_left;

    multilevel_hysteresis_quantizer_core #(.ENTRIES(ENTRIES)) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .sample          (sample),
        .entry_index     (entry_index),
        .entry_threshold (entry_threshold),
        .entry_output    (entry_output),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .level_value     (level_value),
        .level_index     (level_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic level_result_t quantize_sample(input logic signed [DATA_W-1:0] smp);
        int            s;
        int            half;
        int            n;
        int            idx;
        level_result_t r;
        s    = smp;
        half = int'(band_width >> 1);
        n    = int'(levels_set);
        if (n < 1)
            n = 1;
        if (n > ENTRIES)
            n = ENTRIES;
        idx = cur_level;
        if (idx >= n)
            idx = n - 1;
        if (s >= rise_point[idx])
        begin
            while (idx + 1 < n && s >= rise_point[idx + 1] + half)
                idx++;
        end
        else
        begin
            while (idx > 0 && s < rise_point[idx] - half)
                idx--;
        end
        cur_level = idx;
        r.value   = DATA_W'(level_out[idx]);
        r.index   = OUT_IDX_W'(idx);
        return r;
    endfunction

    function automatic dir_row_t wr_row(input logic [ENTRY_W-1:0] idx,
                                        input logic signed [DATA_W-1:0] thr,
                                        input logic signed [DATA_W-1:0] outv);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.thr  = thr;
        r.outv = outv;
        return r;
    endfunction

    function automatic dir_row_t smp_row(input logic signed [DATA_W-1:0] smp);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_SAMPLE;
        r.smp  = smp;
        return r;
    endfunction

    function automatic dir_row_t chk_row(input logic signed [DATA_W-1:0] smp,
                                         input logic signed [DATA_W-1:0] ev,
                                         input logic [OUT_IDX_W-1:0] ei);
        dir_row_t r;
        r           = smp_row(smp);
        r.fixed     = 1'b1;
        r.res.value = ev;
        r.res.index = ei;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] sel,
                                         input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_item(input logic m, input logic signed [DATA_W-1:0] smp,
                             input logic [ENTRY_W-1:0] ei,
                             input logic signed [DATA_W-1:0] thr,
                             input logic signed [DATA_W-1:0] ov,
                             input logic fixed, input level_result_t fixed_res);
        level_result_t r;
        int            gap;
        in_valid        = 1'b1;
        mode            = m;
        sample          = smp;
        entry_index     = ei;
        entry_threshold = thr;
        entry_output    = ov;
        do
            @(posedge clk);
        while (in_stall);
        if (m == MODE_WRITE)
        begin
            rise_point[ei] = thr;
            level_out[ei]  = ov;
        end
        else
        begin
            r = quantize_sample(smp);
            if (fixed)
                r = fixed_res;
            expected_levels.push_back(r);
        end
        item_count++;
        @(negedge clk);
        if (idle_on && !quiet && $urandom_range(0, 99) < 20)
        begin
            gap      = $urandom_range(1, 11);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // let every pending request finish, table writes included
    task automatic wait_idle();
        in_valid = 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        @(posedge clk);
        if (sel == CFG_HYST)
            band_width = val[HYST_W-1:0];
        else
            levels_set = val[LVL_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // well-formed table: non-decreasing breakpoints, wide or tightly packed
    task automatic load_table();
        int th [ENTRIES];
        int base;
        int step;
        int t;
        int j;
        if ($urandom_range(0, 1) == 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                th[i] = int'($urandom_range(0, 65535)) - 32768;
            for (int i = 1; i < ENTRIES; i++)
            begin
                t = th[i];
                j = i - 1;
                while (j >= 0 && th[j] > t)
                begin
                    th[j + 1] = th[j];
                    j--;
                end
                th[j + 1] = t;
            end
        end
        else
        begin
            base = int'($urandom_range(0, 65535)) - 32768;
            step = $urandom_range(0, 300);
            for (int i = 0; i < ENTRIES; i++)
            begin
                th[i] = base + i * step;
                if (th[i] > 32767)
                    th[i] = 32767;
            end
        end
        for (int i = 0; i < ENTRIES; i++)
            send_item(MODE_WRITE, DATA_W'($urandom), ENTRY_W'(i), DATA_W'(th[i]),
                      DATA_W'($urandom), 1'b0, '0);
    endtask

    task automatic random_item();
        int pick;
        int half;
        int s;
        pick = $urandom_range(0, 99);
        half = int'(band_width >> 1);
        if (pick < 2)
            load_table();
        else if (pick < 12)
            send_item(MODE_WRITE, DATA_W'($urandom), ENTRY_W'($urandom), DATA_W'($urandom),
                      DATA_W'($urandom), 1'b0, '0);
        else if (pick < 35)
            send_item(MODE_SAMPLE, DATA_W'($urandom), ENTRY_W'($urandom), DATA_W'($urandom),
                      DATA_W'($urandom), 1'b0, '0);
        else
        begin
            // land close to a breakpoint, inside or just outside the band
            s = rise_point[$urandom_range(0, ENTRIES - 1)]
                + int'($urandom_range(0, 2 * half + 16)) - half - 8;
            if (s > 32767)
                s = 32767;
            if (s < -32768)
                s = -32768;
            send_item(MODE_SAMPLE, DATA_W'(s), ENTRY_W'($urandom), DATA_W'($urandom),
                      DATA_W'($urandom), 1'b0, '0);
        end
    endtask

    always @(negedge clk)
    begin
        if (quiet || !idle_on || !rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 8)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        level_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("level_value: expected none, actual %0d (level_index %0d)",
                       level_value, level_index);
                error_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                if (level_value !== want.value)
                begin
                    $error("level_value: expected %0d, actual %0d", want.value, level_value);
                    error_count++;
                end
                if (level_index !== want.index)
                begin
                    $error("level_index: expected %0d, actual %0d", want.index, level_index);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int            phase;
        int            phase_end;
        int            h;
        int            l;
        level_result_t none;

        none            = '0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_HYST;
        cfg_data        = '0;
        in_valid        = 1'b0;
        mode            = MODE_SAMPLE;
        sample          = '0;
        entry_index     = '0;
        entry_threshold = '0;
        entry_output    = '0;
        out_stall       = 1'b0;
        stall_left      = 0;
        error_count     = 0;
        item_count      = 0;
        idle_on         = 1'b1;
        quiet           = 1'b0;
        band_width      = HYST_W'(2);
        levels_set      = LVL_W'(1);
        cur_level       = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rise_point[i] = 0;
            level_out[i]  = 0;
        end

        dir_rows = '{
            wr_row(4'd0, -16'sd32768, 16'sd32767),
            chk_row(-16'sd32768, 16'sd32767, 4'd0),
            chk_row(16'sd32767, 16'sd32767, 4'd0),
            wr_row(4'd1, 16'sd0, -16'sd32768),
            wr_row(4'd2, 16'sd100, 16'sd0),
            wr_row(4'd3, 16'sd32767, 16'sd1),
            reg_row(CFG_LEVELS, 12'd4),
            reg_row(CFG_HYST, 12'd0),
            chk_row(16'sd32767, 16'sd1, 4'd3),
            chk_row(-16'sd32768, 16'sd32767, 4'd0),
            reg_row(CFG_HYST, 12'd4095),
            smp_row(16'sd50),
            smp_row(16'sd2047),
            smp_row(-16'sd100),
            smp_row(-16'sd2048),
            smp_row(16'sd32767),
            // index left above the new count saturates first
            reg_row(CFG_LEVELS, 12'd2),
            smp_row(16'sd0),
            reg_row(CFG_LEVELS, 12'd0),
            chk_row(16'sd32767, 16'sd32767, 4'd0),
            // breakpoints out of order
            wr_row(4'd0, 16'sd32767, -16'sd1),
            reg_row(CFG_LEVELS, 12'd4),
            smp_row(-16'sd32768),
            smp_row(16'sd100)
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_REG:
                begin
                    wait_idle();
                    write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
                end
                ROW_WRITE:
                    send_item(MODE_WRITE, DATA_W'($urandom), dir_rows[i].idx, dir_rows[i].thr,
                              dir_rows[i].outv, 1'b0, none);
                default:
                    send_item(MODE_SAMPLE, dir_rows[i].smp, ENTRY_W'($urandom),
                              DATA_W'($urandom), DATA_W'($urandom),
                              dir_rows[i].fixed, dir_rows[i].res);
            endcase
        end

        // every entry is written before any count above four is used
        load_table();

        phase = 0;
        while (item_count < ITEMS_TOTAL)
        begin
            wait_idle();
            case (phase)
                0: begin h = 4095; l = 16; end
                1: begin h = 0;    l = 31; end
                2: begin h = 1;    l = 1;  end
                3: begin h = 2;    l = 0;  end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: h = $urandom_range(0, 4095);
                        1: h = $urandom_range(0, 64);
                        2: h = $urandom_range(0, 600);
                        default: h = 4095 - $urandom_range(0, 7);
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        l = $urandom_range(0, 31);
                    else
                        l = $urandom_range(2, 16);
                end
            endcase
            write_reg(CFG_HYST, CFG_DATA_W'(h));
            write_reg(CFG_LEVELS, CFG_DATA_W'(l));
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_end = item_count + PHASE_ITEMS;
            while (item_count < phase_end && item_count < ITEMS_TOTAL)
            begin
                quiet = (item_count >= ITEMS_TOTAL - QUIET_ITEMS);
                random_item();
            end
            phase++;
        end

        quiet = 1'b1;
        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: multilevel_hysteresis_quantizer_core.f
rtl/core/mhq_pkg.sv
rtl/core/mhq_cell.sv
rtl/core/multilevel_hysteresis_quantizer_core.sv
bench/tb_top.sv
